// ===== design/tcw_pkg.sv =====
package tcw_pkg;

  typedef enum logic [2:0] {
    OP_PUT_CURSOR = 3'd0,
    OP_PUT_POS    = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_MOVE       = 3'd3,
    OP_READ       = 3'd4
  } tcw_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MOVE,
    ST_ZERO,
    ST_FILL
  } tcw_state_e;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd15;
  localparam int unsigned REG_DEFAULT_ATTR = 0;

endpackage

// ===== design/tcw_ram.sv =====
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/text_console_writer_top.sv =====
// Channel  Direction  Handshake                 Beat contents
// in       input      in_valid_i / in_ready_o   opcode, char_code, attribute, column, row
// out      output     out_valid_o / out_ready_i cursor, cell_char, cell_attr, scrolled
// cfg      input      APB psel/penable/pwrite   default_attr at byte address 0
//
// A put without scroll, a cursor move and an unused opcode finish straight from idle; a
// read passes through a read state. A put that scrolls copies each row up and zeroes the
// last row, and a clear fills every cell with spaces: both sweep the cell memory one entry
// per cycle through its single write port. The result sits in an output register; a new
// beat is taken while the block is idle and that register is free or being emptied. Reset
// clears the cursor and control state only; the cell memory holds garbage until written.
module text_console_writer_top #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  attribute_i,
  input  logic [6:0]  column_i,
  input  logic [4:0]  row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  cursor_column_o,
  output logic [4:0]  cursor_row_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o,
  output logic        scrolled_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcw_pkg::*;

  localparam int unsigned CELLS  = COLS * ROWS;
  localparam int unsigned N_MOVE = CELLS - COLS;
  localparam int unsigned CW     = $clog2(COLS);
  localparam int unsigned RW     = $clog2(ROWS);
  localparam int unsigned AW     = $clog2(CELLS);

  tcw_state_e state_q, state_d;

  logic [7:0]    def_attr_q;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic          scr_q, scr_d;

  logic          ov_q;
  logic [6:0]    o_col_q;
  logic [4:0]    o_row_q;
  logic [7:0]    o_char_q;
  logic [7:0]    o_attr_q;
  logic          o_scr_q;
  logic          load, load_cell;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  logic          in_acc;
  logic [CW-1:0] col_cl, put_col;
  logic [RW-1:0] row_cl, put_row;
  logic [AW-1:0] cl_addr, put_addr;
  logic          is_nl, wrap, put_scroll;
  logic [7:0]    attr_eff;
  logic          cfg_sel;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == 1'(REG_DEFAULT_ATTR));
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign prdata  = cfg_sel ? {24'd0, def_attr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_attr_q <= ATTR_RESET;
    end else if (cfg_wr) begin
      def_attr_q <= pwdata[7:0];
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && (!ov_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign col_cl = ({2'd0, column_i} > 9'(COLS - 1)) ? CW'(COLS - 1) : CW'(column_i);
  assign row_cl = ({3'd0, row_i} > 8'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(row_i);

  assign put_col = (opcode_i == OP_PUT_CURSOR) ? col_q : col_cl;
  assign put_row = (opcode_i == OP_PUT_CURSOR) ? row_q : row_cl;

  assign cl_addr  = AW'(AW'(row_cl) * AW'(COLS) + AW'(col_cl));
  assign put_addr = AW'(AW'(put_row) * AW'(COLS) + AW'(put_col));

  assign is_nl      = (char_code_i == NEWLINE_CODE);
  assign wrap       = is_nl || (put_col == CW'(COLS - 1));
  assign put_scroll = wrap && (put_row == RW'(ROWS - 1));
  assign attr_eff   = (attribute_i == 8'd0) ? def_attr_q : attribute_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_i)
            OP_PUT_CURSOR, OP_PUT_POS: begin
              if (put_scroll) state_d = ST_MOVE;
            end
            OP_CLEAR: state_d = ST_FILL;
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_MOVE: begin
        if (cnt_q == AW'(N_MOVE)) state_d = ST_ZERO;
      end
      ST_ZERO, ST_FILL: begin
        if (cnt_q == AW'(CELLS - 1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    we        = 1'b0;
    re        = 1'b0;
    waddr     = cnt_q;
    wdata     = 16'd0;
    raddr     = AW'(cnt_q + AW'(COLS));
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    col_d     = col_q;
    row_d     = row_q;
    scr_d     = scr_q;
    load      = 1'b0;
    load_cell = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          scr_d = 1'b0;
          case (opcode_i)
            OP_PUT_CURSOR, OP_PUT_POS: begin
              if (!is_nl) begin
                we    = 1'b1;
                waddr = put_addr;
                wdata = {attr_eff, char_code_i};
              end
              if (put_scroll) begin
                col_d  = '0;
                row_d  = RW'(ROWS - 1);
                cnt_d  = '0;
                pend_d = 1'b0;
                scr_d  = 1'b1;
              end else begin
                load = 1'b1;
                if (wrap) begin
                  col_d = '0;
                  row_d = put_row + 1'b1;
                end else begin
                  col_d = put_col + 1'b1;
                  row_d = put_row;
                end
              end
            end
            OP_CLEAR: begin
              col_d = '0;
              row_d = '0;
              cnt_d = '0;
            end
            OP_MOVE: begin
              col_d = col_cl;
              row_d = row_cl;
              load  = 1'b1;
            end
            OP_READ: begin
              re    = 1'b1;
              raddr = cl_addr;
            end
            default: load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        load      = 1'b1;
        load_cell = 1'b1;
      end
      ST_MOVE: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = cnt_q - 1'b1;
          wdata = rdata;
        end
        if (cnt_q != AW'(N_MOVE)) begin
          re     = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      ST_ZERO: begin
        we    = 1'b1;
        wdata = 16'd0;
        cnt_d = cnt_q + 1'b1;
        load  = (cnt_q == AW'(CELLS - 1));
      end
      ST_FILL: begin
        we    = 1'b1;
        wdata = {def_attr_q, SPACE_CODE};
        cnt_d = cnt_q + 1'b1;
        load  = (cnt_q == AW'(CELLS - 1));
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      scr_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      scr_q   <= scr_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      o_col_q  <= 7'(col_d);
      o_row_q  <= 5'(row_d);
      o_char_q <= load_cell ? rdata[7:0] : 8'd0;
      o_attr_q <= load_cell ? rdata[15:8] : 8'd0;
      o_scr_q  <= scr_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign cursor_column_o = o_col_q;
  assign cursor_row_o    = o_row_q;
  assign cell_char_o     = o_char_q;
  assign cell_attr_o     = o_attr_q;
  assign scrolled_o      = o_scr_q;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import tcw_pkg::*;

  localparam int unsigned COLS = 80;
  localparam int unsigned ROWS = 25;
  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned PHASE_ITEMS = 155;
  localparam int unsigned LONG_HOLD = 600;
  localparam int unsigned SQUEEZE_AT = 250;
  localparam int unsigned IDLE_LIMIT = 8 * (CELLS + COLS) + 2 * LONG_HOLD;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [2:0] ATTR_ADDR = 3'(4 * REG_DEFAULT_ATTR);
  localparam logic [2:0] SPARE_ADDR = 3'(4 * (REG_DEFAULT_ATTR + 1));

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic [7:0] attr;
    logic [6:0] col;
    logic [4:0] row;
  } console_cmd_t;

  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] ch;
    logic [7:0] attr;
    logic       scrolled;
  } console_view_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = '0;
  logic [7:0]  char_code_i = '0;
  logic [7:0]  attribute_i = '0;
  logic [6:0]  column_i = '0;
  logic [4:0]  row_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [6:0]  cursor_column_o;
  logic [4:0]  cursor_row_o;
  logic [7:0]  cell_char_o;
  logic [7:0]  cell_attr_o;
  logic        scrolled_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_writer_top #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .char_code_i    (char_code_i),
    .attribute_i    (attribute_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_column_o(cursor_column_o),
    .cursor_row_o   (cursor_row_o),
    .cell_char_o    (cell_char_o),
    .cell_attr_o    (cell_attr_o),
    .scrolled_o     (scrolled_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  console_cmd_t  pending_q[$];
  console_view_t screen_view_q[$];

  logic [15:0] screen [CELLS];
  int unsigned cursor_at = 0;
  logic [7:0]  dflt_attr = ATTR_RESET;

  int unsigned queued_total = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned read_count = 0;
  int unsigned clear_count = 0;
  int unsigned scroll_count = 0;
  int unsigned attr_settings = 1;
  int unsigned fail_count = 0;

  // Applies one command to the screen image and returns what the block reports.
  function automatic console_view_t console_apply(console_cmd_t c);
    console_view_t v;
    int unsigned col_c;
    int unsigned row_c;
    int unsigned spot;
    int unsigned nxt;
    logic [7:0]  a;
    v = '0;
    col_c = (c.col > COLS - 1) ? COLS - 1 : c.col;
    row_c = (c.row > ROWS - 1) ? ROWS - 1 : c.row;
    spot = row_c * COLS + col_c;
    case (c.op)
      OP_PUT_CURSOR, OP_PUT_POS: begin
        if (c.op == OP_PUT_CURSOR) begin
          spot = cursor_at;
        end
        a = (c.attr == 8'h00) ? dflt_attr : c.attr;
        if (c.ch == NEWLINE_CODE) begin
          nxt = (spot / COLS + 1) * COLS;
        end else begin
          screen[spot] = {a, c.ch};
          nxt = spot + 1;
        end
        if (nxt < CELLS) begin
          cursor_at = nxt;
        end else begin
          for (int unsigned i = 0; i < CELLS - COLS; i++) begin
            screen[i] = screen[i + COLS];
          end
          for (int unsigned i = CELLS - COLS; i < CELLS; i++) begin
            screen[i] = '0;
          end
          cursor_at = CELLS - COLS;
          v.scrolled = 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int unsigned i = 0; i < CELLS; i++) begin
          screen[i] = {dflt_attr, SPACE_CODE};
        end
        cursor_at = 0;
      end
      OP_MOVE: begin
        cursor_at = spot;
      end
      OP_READ: begin
        {v.attr, v.ch} = screen[spot];
      end
      default: begin
      end
    endcase
    v.col = 7'(cursor_at % COLS);
    v.row = 5'(cursor_at / COLS);
    return v;
  endfunction

  function automatic void enqueue(logic [2:0] op, logic [7:0] ch, logic [7:0] attr,
                                  logic [6:0] col, logic [4:0] row);
    pending_q.push_back({op, ch, attr, col, row});
    queued_total++;
    if (op == OP_READ) begin
      read_count++;
    end
    if (op == OP_CLEAR) begin
      clear_count++;
    end
  endfunction

  function automatic logic [7:0] random_attr();
    return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
  endfunction

  function automatic void queue_random_cmd();
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  ch;
    pick = $urandom_range(0, 99);
    ch = ($urandom_range(0, 6) == 0) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
    if (pick < 35) begin
      op = OP_PUT_CURSOR;
    end else if (pick < 55) begin
      op = OP_PUT_POS;
    end else if (pick < 57) begin
      op = OP_CLEAR;
    end else if (pick < 67) begin
      op = OP_MOVE;
    end else if (pick < 96) begin
      op = OP_READ;
    end else begin
      op = 3'($urandom_range(int'(OP_READ) + 1, 7));
    end
    enqueue(op, ch, random_attr(), 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
  endfunction

  // A line of text: place the cursor, type a run of characters, then end the line.
  function automatic void queue_text_line();
    int unsigned len;
    logic [7:0]  ch;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(COLS, 2 * COLS) : $urandom_range(1, 30);
    enqueue(OP_MOVE, 8'h00, 8'h00, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
    repeat (len) begin
      ch = 8'($urandom_range(0, 255));
      if (ch == NEWLINE_CODE) begin
        ch = SPACE_CODE;
      end
      enqueue(OP_PUT_CURSOR, ch, random_attr(), 7'($urandom_range(0, 127)),
              5'($urandom_range(0, 31)));
    end
    enqueue(OP_PUT_CURSOR, NEWLINE_CODE, random_attr(), 7'($urandom_range(0, 127)),
            5'($urandom_range(0, 31)));
  endfunction

  task automatic drain();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || screen_view_q.size() != 0 || in_valid_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ATTR_ADDR) begin
      dflt_attr = data[7:0];
      attr_settings++;
    end
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [2:0] addr, input logic [31:0] data);
    int unsigned goal;
    reg_write(addr, data);
    goal = queued_total + PHASE_ITEMS;
    while (queued_total < goal) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_text_line();
      end else begin
        queue_random_cmd();
      end
    end
    drain();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : sender
    int unsigned burst_left;
    int unsigned gap_left;
    console_cmd_t sent;
    console_cmd_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        sent = {opcode_i, char_code_i, attribute_i, column_i, row_i};
        screen_view_q.push_back(console_apply(sent));
        beats_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          opcode_i <= nxt.op;
          char_code_i <= nxt.ch;
          attribute_i <= nxt.attr;
          column_i <= nxt.col;
          row_i <= nxt.row;
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            if ($urandom_range(0, 5) == 0) begin
              burst_left = $urandom_range(40, 80);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 16);
              gap_left = $urandom_range(0, 8);
            end
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned taken;
    bit          squeezed;
    rx_mode_e    mode;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      mode_left = 0;
      taken = 0;
      squeezed = 1'b0;
      mode = RX_OPEN;
    end else begin
      if (out_valid_o && out_ready_i) begin
        taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!squeezed && taken >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        hold_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready_i <= (mode_left % 4 == 0);
          default:   out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    console_view_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (screen_view_q.size() == 0) begin
        $error("Result beat arrived with no command outstanding.");
        fail_count++;
      end else begin
        want = screen_view_q.pop_front();
        if (want.scrolled) begin
          scroll_count++;
        end
        check_field("cursor_column", 8'(want.col), 8'(cursor_column_o));
        check_field("cursor_row", 8'(want.row), 8'(cursor_row_o));
        check_field("cell_char", want.ch, cell_char_o);
        check_field("cell_attr", want.attr, cell_attr_o);
        check_field("scrolled", 8'(want.scrolled), 8'(scrolled_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles.", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Before the first clear, reads only touch cells that were written here.
    enqueue(OP_PUT_POS, 8'h41, 8'h1E, 7'd0, 5'd0);
    enqueue(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    enqueue(OP_PUT_POS, 8'h7F, 8'h00, 7'(COLS - 1), 5'd0);
    enqueue(OP_READ, 8'h00, 8'h00, 7'(COLS - 1), 5'd0);
    enqueue(OP_PUT_POS, 8'h51, 8'hC3, 7'h7F, 5'h1F);
    enqueue(OP_READ, 8'h00, 8'h00, 7'(COLS - 1), 5'(ROWS - 2));
    enqueue(OP_READ, 8'h00, 8'h00, 7'h7F, 5'h1F);
    enqueue(OP_MOVE, 8'h00, 8'h00, 7'd5, 5'd3);
    enqueue(OP_PUT_CURSOR, 8'hFF, 8'hFF, 7'd0, 5'd0);
    enqueue(OP_READ, 8'h00, 8'h00, 7'd5, 5'd3);
    enqueue(OP_PUT_CURSOR, NEWLINE_CODE, 8'h00, 7'd0, 5'd0);
    enqueue(OP_MOVE, 8'h00, 8'h00, 7'd0, 5'd30);
    enqueue(OP_PUT_CURSOR, NEWLINE_CODE, 8'h07, 7'h7F, 5'h1F);
    for (int op = int'(OP_READ) + 1; op < 8; op++) begin
      enqueue(3'(op), 8'hAA, 8'h55, 7'd9, 5'd9);
    end
    enqueue(OP_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0);
    enqueue(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    enqueue(OP_PUT_POS, 8'h00, 8'h80, 7'd40, 5'd12);
    enqueue(OP_READ, 8'h00, 8'h00, 7'd40, 5'd12);
    enqueue(OP_MOVE, 8'h00, 8'h00, 7'(COLS - 1), 5'(ROWS - 1));
    enqueue(OP_PUT_CURSOR, 8'h5A, 8'h00, 7'd0, 5'd0);
    enqueue(OP_PUT_POS, NEWLINE_CODE, 8'h00, 7'd3, 5'(ROWS - 1));
    enqueue(OP_READ, 8'h00, 8'h00, 7'(COLS - 1), 5'(ROWS - 3));
    drain();

    run_phase(ATTR_ADDR, 32'h0000_0000);
    run_phase(ATTR_ADDR, 32'h0000_00FF);
    run_phase(ATTR_ADDR, $urandom);
    run_phase(ATTR_ADDR, {24'hA5A5A5, 8'h01});
    run_phase(SPARE_ADDR, 32'h0000_0033);
    run_phase(ATTR_ADDR, $urandom);

    repeat (2 * (CELLS + COLS)) @(negedge clk_i);
    $display("Sent %0d commands and checked %0d result beats, with %0d reads and %0d clears,",
             beats_in, beats_out, read_count, clear_count);
    $display("%0d scrolls and %0d default attribute settings.", scroll_count, attr_settings);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== text_console_writer_top.f =====
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer_top.sv
tb/testbench.sv
